// ===== src/drst_pkg.sv =====
`timescale 1ns / 1ps

package drst_pkg;

    // Weight store layout: output row times three plus input column.
    localparam int WEIGHT_COUNT = 9;
    localparam int ROW_STRIDE   = 3;
    localparam int MAX_ENTRIES  = 4096;

    // Item commands.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRAIN = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Training status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_TRAINING  = 2'd0;
    localparam t_status ST_CONVERGED = 2'd1;
    localparam t_status ST_GAVE_UP   = 2'd2;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_RATE      = 2'd0;
    localparam t_cfg_index CFG_GAIN      = 2'd1;
    localparam t_cfg_index CFG_THRESHOLD = 2'd2;
    localparam t_cfg_index CFG_MAX_EPOCH = 2'd3;

    typedef logic [15:0] t_rom [MAX_ENTRIES];

    // Shift-subtract division, used only while the table is elaborated.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Bipolar sigmoid table: entry k is tanh(8k/entries) in Q1.14, built from a
    // truncated series for the exponential step and a running product.
    function automatic t_rom build_rom(input int entries);
        t_rom        rom;
        logic [63:0] one;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] base;
        logic [63:0] ek;
        logic [63:0] num;
        rom  = '{default: '0};
        one  = 64'd1 << 30;
        term = one;
        sum  = one;
        for (int n = 1; n <= 10; n++) begin
            term = udiv64(term * 64'd16, 64'(entries) * 64'(n));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        base = sum;
        ek   = one;
        for (int k = 0; k < entries; k++) begin
            num    = (one - ek) * 64'd32768 + (one + ek);
            rom[k] = 16'(udiv64(num, 64'd2 * (one + ek)));
            ek     = (ek * base + (one >> 1)) >> 30;
        end
        return rom;
    endfunction

endpackage

// ===== src/delta_rule_sigmoid_trainer.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------------
// input     | in        | i_in_valid / o_in_ready   | command, index, weight, x, targets
// output    | out       | o_out_valid / i_out_ready | outputs, error, epochs, status, read
// config    | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item at a time; all products go through one shared 41x17 multiplier.
// Training item: for each output row, a net input sum over the inputs, a sigmoid lookup
// and, while training goes on, the error, slope and an update of each weight in the row.
// Reset is synchronous and active low; weights read as zero until written.
// A new item is taken while a result still waits; the result stalls only at its end.

module delta_rule_sigmoid_trainer
    import drst_pkg::*;
#(
    parameter int INPUT_COUNT     = 3,
    parameter int OUTPUT_COUNT    = 3,
    parameter int SIGMOID_ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic [3:0]         i_weight_index,
    input  logic signed [31:0] i_weight_value,
    input  logic signed [15:0] i_x_first,
    input  logic signed [15:0] i_x_second,
    input  logic signed [15:0] i_x_third,
    input  logic signed [15:0] i_target_first,
    input  logic signed [15:0] i_target_second,
    input  logic signed [15:0] i_target_third,
    input  logic               i_epoch_end,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_out_first,
    output logic signed [15:0] o_out_second,
    output logic signed [15:0] o_out_third,
    output logic [23:0]        o_epoch_error,
    output logic [15:0]        o_epoch_count,
    output logic [1:0]         o_train_status,
    output logic signed [31:0] o_weight_read
);

    localparam int IW = $clog2(SIGMOID_ENTRIES);
    localparam t_rom SIG_ROM = build_rom(SIGMOID_ENTRIES);

    typedef enum logic [17:0] {
        S_IDLE  = 18'd1 << 0,
        S_WRW   = 18'd1 << 1,
        S_RD    = 18'd1 << 2,
        S_RDW   = 18'd1 << 3,
        S_NRD   = 18'd1 << 4,
        S_NMUL  = 18'd1 << 5,
        S_NACC  = 18'd1 << 6,
        S_GAIN  = 18'd1 << 7,
        S_SCALE = 18'd1 << 8,
        S_ROM   = 18'd1 << 9,
        S_SIGN  = 18'd1 << 10,
        S_ESQ   = 18'd1 << 11,
        S_EMUL  = 18'd1 << 12,
        S_DL    = 18'd1 << 13,
        S_HOLD  = 18'd1 << 14,
        S_URD   = 18'd1 << 15,
        S_UWR   = 18'd1 << 16,
        S_DONE  = 18'd1 << 17
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [15:0] r_rate;
    logic [15:0] r_gain;
    logic [23:0] r_thr;
    logic [15:0] r_maxep;

    // Training bookkeeping.
    logic [23:0] r_err;
    logic [15:0] r_epochs;
    t_status     r_status;

    // Latched item.
    t_cmd               r_cmd;
    logic [3:0]         r_idx;
    logic signed [31:0] r_wval;
    logic signed [15:0] r_x [3];
    logic signed [15:0] r_d [3];
    logic               r_eend;

    // Sequencer and datapath.
    logic [1:0]         r_row;
    logic [1:0]         r_col;
    logic signed [51:0] r_net;
    logic signed [57:0] r_prod;
    logic               r_sat;
    logic [15:0]        r_rom;
    logic signed [15:0] r_oc;
    logic signed [15:0] r_o [3];
    logic [14:0]        r_g;
    logic signed [34:0] r_rdl;
    logic signed [31:0] r_wread;
    logic               r_rd_ok;
    logic [WEIGHT_COUNT-1:0] r_wvalid;

    // Output register.
    logic               r_out_valid;
    logic signed [15:0] r_out_o [3];
    logic [23:0]        r_out_err;
    logic [15:0]        r_out_ep;
    t_status            r_out_st;
    logic signed [31:0] r_out_wr;

    logic               w_in_acc;
    logic               w_out_load;
    logic               w_stopped;
    logic               w_col_last;
    logic               w_row_last;
    logic [3:0]         w_cur;
    logic [3:0]         w_raddr;
    logic [3:0]         w_waddr;
    logic               w_we;
    logic [31:0]        w_wdata;
    logic [31:0]        w_ram_q;
    logic signed [31:0] w_rdat;
    logic signed [40:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [57:0] w_mul;
    logic [51:0]        w_abs;
    logic [15:0]        w_t;
    logic signed [15:0] w_o;
    logic signed [16:0] w_e;
    logic [28:0]        w_g_full;
    logic [32:0]        w_eterm;
    logic [24:0]        w_err_sum;
    logic signed [32:0] w_dl_full;
    logic signed [17:0] w_dl;
    logic signed [51:0] w_dw_full;
    logic signed [33:0] w_dw;
    logic signed [34:0] w_wsum;
    logic signed [31:0] w_wsat;
    logic               w_ep_inc;
    logic [15:0]        n_epochs;
    t_status            n_status;
    logic [23:0]        n_err;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_stopped  = (r_status != ST_TRAINING);
    assign w_col_last = (r_col == 2'(INPUT_COUNT - 1));
    assign w_row_last = (r_row == 2'(OUTPUT_COUNT - 1));

    // Weight store addressing.
    assign w_cur   = 4'(r_row) * 4'(ROW_STRIDE) + 4'(r_col);
    assign w_raddr = (r_state == S_RD) ? r_idx : w_cur;
    assign w_waddr = (r_state == S_WRW) ? r_idx : w_cur;
    assign w_we    = ((r_state == S_WRW) && (r_idx < 4'(WEIGHT_COUNT))) || (r_state == S_UWR);
    assign w_wdata = (r_state == S_WRW) ? r_wval : w_wsat;
    assign w_rdat  = r_rd_ok ? $signed(w_ram_q) : 32'sd0;

    drst_ram #(
        .WIDTH (32),
        .DEPTH (WEIGHT_COUNT)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // Sigmoid lookup terms.
    assign w_abs = r_net[51] ? (~r_net + 52'd1) : r_net;
    assign w_t   = r_sat ? 16'd16384 : r_rom;
    assign w_o   = r_net[51] ? -$signed(w_t) : $signed(w_t);

    // Error, slope and update terms.
    assign w_e       = 17'(r_d[r_row]) - 17'(r_oc);
    assign w_g_full  = 29'd268435456 - r_prod[28:0];
    assign w_eterm   = r_prod[32:0] + 33'd4096;
    assign w_err_sum = {1'b0, r_err} + 25'(w_eterm[32:13]);
    assign w_dl_full = $signed(r_prod[32:0]) + 33'sd16384;
    assign w_dl      = w_dl_full[32:15];
    assign w_dw_full = $signed(r_prod[51:0]) + 52'sd131072;
    assign w_dw      = w_dw_full[51:18];
    assign w_wsum    = 35'(w_rdat) + 35'(w_dw);

    // New weight clamps to the 32-bit range.
    always_comb begin
        if (w_wsum[34:31] == 4'b0000 || w_wsum[34:31] == 4'b1111) begin
            w_wsat = w_wsum[31:0];
        end else if (w_wsum[34]) begin
            w_wsat = 32'sh80000000;
        end else begin
            w_wsat = 32'sh7FFFFFFF;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_NMUL: begin
                w_mul_a = 41'(w_rdat);
                w_mul_b = 17'(r_x[r_col]);
            end
            S_GAIN: begin
                w_mul_a = {1'b0, w_abs[39:0]};
                w_mul_b = {1'b0, r_gain};
            end
            S_SCALE: begin
                w_mul_a = {1'b0, r_prod[39:0]};
                w_mul_b = 17'(SIGMOID_ENTRIES);
            end
            S_SIGN: begin
                w_mul_a = 41'(w_o);
                w_mul_b = 17'(w_o);
            end
            S_ESQ: begin
                w_mul_a = 41'(w_e);
                w_mul_b = w_e;
            end
            S_EMUL: begin
                w_mul_a = 41'(w_e);
                w_mul_b = {2'b00, r_g};
            end
            S_DL: begin
                w_mul_a = 41'(w_dl);
                w_mul_b = {1'b0, r_rate};
            end
            S_URD: begin
                w_mul_a = 41'(r_rdl);
                w_mul_b = 17'(r_x[r_col]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = w_mul_a * w_mul_b;

    // Epoch bookkeeping at the end of an item.
    assign w_ep_inc = (r_cmd == CMD_TRAIN) && r_eend && (r_status == ST_TRAINING);

    always_comb begin
        n_epochs = r_epochs;
        n_status = r_status;
        n_err    = r_err;
        if (r_cmd == CMD_WRITE) begin
            n_epochs = '0;
            n_status = ST_TRAINING;
            n_err    = '0;
        end else if (w_ep_inc) begin
            if (r_epochs != 16'hFFFF) begin
                n_epochs = r_epochs + 16'd1;
            end
            if (r_err <= r_thr) begin
                n_status = ST_CONVERGED;
            end else if (n_epochs >= r_maxep) begin
                n_status = ST_GAVE_UP;
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (t_cmd'(i_command))
                        CMD_WRITE: n_state = S_WRW;
                        CMD_READ:  n_state = S_RD;
                        CMD_TRAIN: n_state = S_NRD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_WRW:   n_state = S_DONE;
            S_RD:    n_state = S_RDW;
            S_RDW:   n_state = S_DONE;
            S_NRD:   n_state = S_NMUL;
            S_NMUL:  n_state = S_NACC;
            S_NACC:  n_state = w_col_last ? S_GAIN : S_NRD;
            S_GAIN:  n_state = S_SCALE;
            S_SCALE: n_state = S_ROM;
            S_ROM:   n_state = S_SIGN;
            S_SIGN: begin
                if (!w_stopped) begin
                    n_state = S_ESQ;
                end else begin
                    n_state = w_row_last ? S_DONE : S_NRD;
                end
            end
            S_ESQ:   n_state = S_EMUL;
            S_EMUL:  n_state = S_DL;
            S_DL:    n_state = S_HOLD;
            S_HOLD:  n_state = S_URD;
            S_URD:   n_state = S_UWR;
            S_UWR: begin
                if (!w_col_last) begin
                    n_state = S_URD;
                end else begin
                    n_state = w_row_last ? S_DONE : S_NRD;
                end
            end
            S_DONE:  n_state = w_out_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= 16'd2048;
            r_gain      <= 16'd4096;
            r_thr       <= 24'd6554;
            r_maxep     <= 16'd50000;
            r_err       <= '0;
            r_epochs    <= '0;
            r_status    <= ST_TRAINING;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RATE:      r_rate  <= i_cfg_data[15:0];
                    CFG_GAIN:      r_gain  <= i_cfg_data[15:0];
                    CFG_THRESHOLD: r_thr   <= i_cfg_data;
                    CFG_MAX_EPOCH: r_maxep <= i_cfg_data[15:0];
                    default:       r_rate  <= r_rate;
                endcase
            end
            if (w_we) begin
                r_wvalid[w_waddr] <= 1'b1;
            end
            // Error terms of each output row accumulate with saturation.
            if (r_state == S_EMUL) begin
                r_err <= w_err_sum[24] ? 24'hFFFFFF : w_err_sum[23:0];
            end
            if (w_out_load) begin
                r_epochs <= n_epochs;
                r_status <= n_status;
                r_err    <= (w_ep_inc && n_status == ST_TRAINING) ? 24'd0 : n_err;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod  <= w_mul;
        r_rd_ok <= (w_raddr < 4'(WEIGHT_COUNT)) && r_wvalid[w_raddr];
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_cmd   <= t_cmd'(i_command);
                    r_idx   <= i_weight_index;
                    r_wval  <= i_weight_value;
                    r_x[0]  <= i_x_first;
                    r_x[1]  <= i_x_second;
                    r_x[2]  <= i_x_third;
                    r_d[0]  <= i_target_first;
                    r_d[1]  <= i_target_second;
                    r_d[2]  <= i_target_third;
                    r_eend  <= i_epoch_end;
                    r_row   <= '0;
                    r_col   <= '0;
                    r_net   <= '0;
                    r_o[0]  <= '0;
                    r_o[1]  <= '0;
                    r_o[2]  <= '0;
                    r_wread <= '0;
                end
            end
            S_RDW: begin
                r_wread <= w_rdat;
            end
            S_NACC: begin
                r_net <= r_net + r_prod[51:0];
                r_col <= w_col_last ? 2'd0 : r_col + 2'd1;
            end
            S_GAIN: begin
                // A zero gain gives a zero output however large the net input is.
                r_sat <= (|w_abs[51:40]) && (r_gain != 16'd0);
            end
            S_SCALE: begin
                r_sat <= r_sat | (|r_prod[57:40]);
            end
            S_ROM: begin
                r_rom <= SIG_ROM[r_prod[40 +: IW]];
            end
            S_SIGN: begin
                r_oc       <= w_o;
                r_o[r_row] <= w_o;
                if (w_stopped) begin
                    r_row <= r_row + 2'd1;
                    r_col <= '0;
                    r_net <= '0;
                end
            end
            S_ESQ: begin
                r_g <= w_g_full[28:14];
            end
            S_HOLD: begin
                r_rdl <= r_prod[34:0];
                r_col <= '0;
            end
            S_UWR: begin
                if (w_col_last) begin
                    r_row <= r_row + 2'd1;
                    r_col <= '0;
                    r_net <= '0;
                end else begin
                    r_col <= r_col + 2'd1;
                end
            end
            default: begin
                r_row <= r_row;
            end
        endcase
        if (w_out_load) begin
            r_out_o[0] <= r_o[0];
            r_out_o[1] <= r_o[1];
            r_out_o[2] <= r_o[2];
            r_out_err  <= n_err;
            r_out_ep   <= n_epochs;
            r_out_st   <= n_status;
            r_out_wr   <= r_wread;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_first    = r_out_o[0];
    assign o_out_second   = r_out_o[1];
    assign o_out_third    = r_out_o[2];
    assign o_epoch_error  = r_out_err;
    assign o_epoch_count  = r_out_ep;
    assign o_train_status = r_out_st;
    assign o_weight_read  = r_out_wr;

`ifndef SYNTH
    // Once training has stopped, a training item leaves the weights alone.
    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cmd == CMD_TRAIN && r_status != ST_TRAINING && r_state != S_IDLE) |-> !w_we)
        else $error("weight written after training stopped");

    // A weight write item restarts the bookkeeping.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_cmd == CMD_WRITE) |=>
        (r_err == 24'd0 && r_epochs == 16'd0 && r_status == ST_TRAINING))
        else $error("bookkeeping not cleared by weight write");

    // An accepted item always starts the sequencer.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("item accepted without starting work");
`endif

endmodule

// ===== src/drst_ram.sv =====
`timescale 1ns / 1ps

module drst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import drst_pkg::*;

    localparam int TBL_SIZE    = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 100;

    // One input item and one result item as the ports carry them.
    typedef struct {
        t_cmd               cmd;
        logic [3:0]         idx;
        logic signed [31:0] wval;
        logic signed [15:0] x0, x1, x2;
        logic signed [15:0] d0, d1, d2;
        logic               ee;
    } t_item;

    typedef struct {
        logic signed [15:0] o0, o1, o2;
        logic [23:0]        err;
        logic [15:0]        cnt;
        t_status            stat;
        logic signed [31:0] wrd;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_command = '0;
    logic [3:0]         i_weight_index = '0;
    logic signed [31:0] i_weight_value = '0;
    logic signed [15:0] i_x_first = '0;
    logic signed [15:0] i_x_second = '0;
    logic signed [15:0] i_x_third = '0;
    logic signed [15:0] i_target_first = '0;
    logic signed [15:0] i_target_second = '0;
    logic signed [15:0] i_target_third = '0;
    logic               i_epoch_end = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_out_first;
    logic signed [15:0] o_out_second;
    logic signed [15:0] o_out_third;
    logic [23:0]        o_epoch_error;
    logic [15:0]        o_epoch_count;
    logic [1:0]         o_train_status;
    logic signed [31:0] o_weight_read;

    delta_rule_sigmoid_trainer u_top (.*);

    // Predictor state and configuration copy.
    logic [15:0]  tanh_tbl [TBL_SIZE];
    longint       net_w [9];
    longint       err_acc;
    longint       epochs;
    t_status      status_q;
    longint       rate_q, gain_q, thresh_q, max_ep_q;

    t_item        pending_items [$];
    t_result      expected_results [$];
    t_item        cur_item;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           mismatches = 0;
    longint       cycles = 0;

    // Tanh table: exponential step from a truncated series, then a running product.
    function automatic void build_tanh_tbl();
        longint          term, acc;
        longint unsigned base, ek, num, one;
        one  = 64'd1 << 30;
        term = longint'(one);
        acc  = longint'(one);
        for (int n = 1; n <= 10; n++) begin
            term = (term * 16) / (longint'(TBL_SIZE) * n);
            acc  = (n % 2 == 1) ? acc - term : acc + term;
        end
        base = longint'(acc);
        ek   = one;
        for (int k = 0; k < TBL_SIZE; k++) begin
            num         = (one - ek) * 64'd32768 + (one + ek);
            tanh_tbl[k] = 16'(num / (64'd2 * (one + ek)));
            ek          = (ek * base + (one >> 1)) >> 30;
        end
    endfunction

    function automatic longint bipolar_sigmoid(input longint net);
        longint unsigned a, p, lim;
        longint          t;
        lim = 64'd1 << 40;
        a   = (net < 0) ? -net : net;
        if (gain_q == 0) begin
            t = 0;
        end else if (a >= lim) begin
            t = 16384;
        end else begin
            p = a * longint'(gain_q);
            if (p >= lim) t = 16384;
            else t = tanh_tbl[((p * TBL_SIZE) >> 40) % TBL_SIZE];
        end
        return (net < 0) ? -t : t;
    endfunction

    // Half-up rounding right shift.
    function automatic longint round_shr(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Applies one item to the predictor and returns the result it should produce.
    function automatic t_result train_and_report(input t_item it);
        t_result r;
        longint  x [3];
        longint  d [3];
        longint  o [3];
        longint  net, e, g, dl, w;
        x = '{longint'(it.x0), longint'(it.x1), longint'(it.x2)};
        d = '{longint'(it.d0), longint'(it.d1), longint'(it.d2)};
        o = '{0, 0, 0};
        r.wrd = '0;
        case (it.cmd)
            CMD_WRITE: begin
                if (it.idx < 9) net_w[it.idx] = longint'(it.wval);
                err_acc  = 0;
                epochs   = 0;
                status_q = ST_TRAINING;
            end
            CMD_READ: begin
                if (it.idx < 9) r.wrd = 32'(net_w[it.idx]);
            end
            CMD_TRAIN: begin
                for (int i = 0; i < 3; i++) begin
                    net = 0;
                    for (int j = 0; j < 3; j++) net += net_w[i * 3 + j] * x[j];
                    o[i] = bipolar_sigmoid(net);
                end
                if (status_q == ST_TRAINING) begin
                    for (int i = 0; i < 3; i++) begin
                        e = d[i] - o[i];
                        err_acc += (e * e + 4096) >>> 13;
                    end
                    if (err_acc > 24'hFFFFFF) err_acc = 24'hFFFFFF;
                    for (int i = 0; i < 3; i++) begin
                        e  = d[i] - o[i];
                        g  = ((64'sd1 <<< 28) - o[i] * o[i]) >>> 14;
                        dl = round_shr(e * g, 15);
                        for (int j = 0; j < 3; j++) begin
                            w = net_w[i * 3 + j] + round_shr(rate_q * dl * x[j], 18);
                            if (w > 64'sd2147483647) w = 64'sd2147483647;
                            if (w < -64'sd2147483648) w = -64'sd2147483648;
                            net_w[i * 3 + j] = w;
                        end
                    end
                    if (it.ee) begin
                        if (epochs < 65535) epochs++;
                        if (err_acc <= thresh_q) status_q = ST_CONVERGED;
                        else if (epochs >= max_ep_q) status_q = ST_GAVE_UP;
                    end
                end
            end
            default: ;
        endcase
        r.o0   = 16'(o[0]);
        r.o1   = 16'(o[1]);
        r.o2   = 16'(o[2]);
        r.err  = 24'(err_acc);
        r.cnt  = 16'(epochs);
        r.stat = status_q;
        // A closed epoch that keeps training starts its error from zero.
        if (it.cmd == CMD_TRAIN && it.ee && status_q == ST_TRAINING) err_acc = 0;
        return r;
    endfunction

    // Clock and cycle limit.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Driver: presents queued items, predicting each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) expected_results.push_back(train_and_report(cur_item));
            if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                cur_item = pending_items.pop_front();
                i_command       <= cur_item.cmd;
                i_weight_index  <= cur_item.idx;
                i_weight_value  <= cur_item.wval;
                i_x_first       <= cur_item.x0;
                i_x_second      <= cur_item.x1;
                i_x_third       <= cur_item.x2;
                i_target_first  <= cur_item.d0;
                i_target_second <= cur_item.d1;
                i_target_third  <= cur_item.d2;
                i_epoch_end     <= cur_item.ee;
                i_in_valid      <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result item at cycle %0d", cycles);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_out_first !== exp_r.o0 || o_out_second !== exp_r.o1 ||
                        o_out_third !== exp_r.o2 || o_epoch_error !== exp_r.err ||
                        o_epoch_count !== exp_r.cnt || o_train_status !== exp_r.stat ||
                        o_weight_read !== exp_r.wrd) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Result mismatch at cycle %0d:", cycles);
                            $display("  expected o=%0d %0d %0d err=%0d cnt=%0d st=%0d rd=%0d",
                                     exp_r.o0, exp_r.o1, exp_r.o2, exp_r.err, exp_r.cnt,
                                     exp_r.stat, exp_r.wrd);
                            $display("  actual   o=%0d %0d %0d err=%0d cnt=%0d st=%0d rd=%0d",
                                     o_out_first, o_out_second, o_out_third, o_epoch_error,
                                     o_epoch_count, o_train_status, o_weight_read);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic add_item(input t_cmd c, input int idx, input int w,
                            input int x0, input int x1, input int x2,
                            input int d0, input int d1, input int d2, input bit ee);
        t_item it;
        it.cmd = c;
        it.idx = 4'(idx);
        it.wval = 32'(w);
        it.x0 = 16'(x0);
        it.x1 = 16'(x1);
        it.x2 = 16'(x2);
        it.d0 = 16'(d0);
        it.d1 = 16'(d1);
        it.d2 = 16'(d2);
        it.ee = ee;
        pending_items.push_back(it);
    endtask

    // Mostly training epochs of small well-formed patterns, with writes, reads and noise.
    task automatic add_random_items(input int count);
        t_item it;
        int    sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 10) it.cmd = CMD_WRITE;
            else if (sel < 80) it.cmd = CMD_TRAIN;
            else if (sel < 95) it.cmd = CMD_READ;
            else it.cmd = CMD_NONE;
            it.idx = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
            if ($urandom_range(7) == 0) it.wval = 32'($urandom);
            else it.wval = 32'(int'($urandom_range(262144)) - 131072);
            if ($urandom_range(7) == 0) begin
                it.x0 = 16'($urandom);
                it.x1 = 16'($urandom);
                it.x2 = 16'($urandom);
            end else begin
                it.x0 = 16'(int'($urandom_range(1024)) - 512);
                it.x1 = 16'(int'($urandom_range(1024)) - 512);
                it.x2 = ($urandom_range(1) == 0) ? -16'sd256 : 16'(int'($urandom_range(1024)) - 512);
            end
            if ($urandom_range(9) == 0) begin
                it.d0 = 16'($urandom);
                it.d1 = 16'($urandom);
                it.d2 = 16'($urandom);
            end else begin
                it.d0 = 16'(int'($urandom_range(32768)) - 16384);
                it.d1 = 16'(int'($urandom_range(32768)) - 16384);
                it.d2 = 16'(int'($urandom_range(32768)) - 16384);
            end
            it.ee = ($urandom_range(3) == 0);
            pending_items.push_back(it);
        end
    endtask

    // Sender holds off until every expected result is in, then the block settles.
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_index idx, input int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 24'(value);
        case (idx)
            CFG_RATE:      rate_q   = value & 16'hFFFF;
            CFG_GAIN:      gain_q   = value & 16'hFFFF;
            CFG_THRESHOLD: thresh_q = value & 24'hFFFFFF;
            default:       max_ep_q = value & 16'hFFFF;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int rate, input int gain, input int thr, input int maxe);
        write_cfg(CFG_RATE, rate);
        write_cfg(CFG_GAIN, gain);
        write_cfg(CFG_THRESHOLD, thr);
        write_cfg(CFG_MAX_EPOCH, maxe);
    endtask

    initial begin
        build_tanh_tbl();
        foreach (net_w[i]) net_w[i] = 0;
        err_acc  = 0;
        epochs   = 0;
        status_q = ST_TRAINING;
        rate_q   = 2048;
        gain_q   = 4096;
        thresh_q = 6554;
        max_ep_q = 50000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, bad indexes, saturation, convergence and frozen state.
        add_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_TRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 0, 32'h7FFFFFFF, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 1, 32'h80000000, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 2, 32'h00010000, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 9, 5, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 15, -1, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_READ, 9, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_READ, 15, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_TRAIN, 0, 0, 32767, -32768, -256, 16384, -16384, 0, 0);
        add_item(CMD_TRAIN, 0, 0, 256, 0, -256, 32767, -32768, 0, 0);
        add_item(CMD_NONE, 15, -1, -1, -1, -1, -1, -1, -1, 1);
        add_item(CMD_WRITE, 0, 32'h8000, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 1, -32'h8000, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 2, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_TRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        add_item(CMD_TRAIN, 0, 0, 512, 256, -256, 16384, 16384, 16384, 1);
        add_item(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 4, 32'h20000, 0, 0, 0, 0, 0, 0, 0);
        add_item(CMD_TRAIN, 0, 0, 300, -300, -256, 8000, -8000, 100, 0);
        add_item(CMD_TRAIN, 0, 0, -300, 300, -256, -8000, 8000, -100, 1);
        drain();

        // Random phase one: sender idles lightly, receiver often.
        set_config(4096, 4096, 6554, 3);
        tx_idle_pct = 18;
        rx_idle_pct = 55;
        add_random_items(260);
        drain();

        // Random phase two: extreme settings, idling swapped.
        set_config(65535, 65535, 16777215, 1);
        tx_idle_pct = 55;
        rx_idle_pct = 18;
        add_random_items(140);
        drain();
        set_config(0, 1, 0, 65535);
        add_random_items(120);
        drain();

        // Random phase three: no idling on either side.
        set_config(2048, 4096, 6554, 50000);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_items(280);
        drain();

        if (expected_results.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
